### design/skrt_pkg.sv
// Shared types, sizes and codes of the sorted key record table.
package skrt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int LABEL_CHARS = 24;
  localparam int LABEL_SLOTS = 24;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [31:0] QTY_MAX = 32'h7fff_ffff;
  localparam logic [31:0] QTY_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_DUMP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // One record; key sits in the low bits so the struct matches the stream payload.
  typedef struct packed {
    logic [63:0] label_high;
    logic [63:0] label_mid;
    logic [63:0] label_low;
    logic [31:0] quantity;
    logic [31:0] key;
  } record_t;

  localparam int REC_W = $bits(record_t);

  // Broadcast commands to every cell of the row.
  typedef struct packed {
    logic ins;
    logic upd;
    logic rot;
  } cell_ctl_t;

  // Clear characters past the first zero character and past the name limit.
  function automatic logic [8*LABEL_SLOTS-1:0] clean_label(input logic [8*LABEL_SLOTS-1:0] w);
    logic [8*LABEL_SLOTS-1:0] res;
    logic                     ok;
    res = '0;
    for (int i = 0; i < LABEL_SLOTS; i++) begin
      ok = (i < LABEL_CHARS);
      for (int j = 0; j <= i; j++) begin
        ok = ok && (w[j*8 +: 8] != 8'h00);
      end
      if (ok) begin
        res[i*8 +: 8] = w[i*8 +: 8];
      end
    end
    return res;
  endfunction

endpackage

### design/sorted_key_record_table_unit.sv
// Sorted key record table: request decode, record count, dump sequencing, output register.
//
// Records live in a row of TABLE_DEPTH cells kept in ascending signed key order; every
// cell compares its key with the request key in the same cycle. Insert, search and
// update each give one result; a request is accepted whenever no dump is running and the
// output register is empty or being drained in that cycle. A dump holds off new
// requests while the cell ring rotates one place per cycle through all TABLE_DEPTH
// places, pausing while a record waits for out_tready, and presents records in key
// order from the head cell. A dump of an empty table gives one not-found result at
// once. The table needs no clearing after reset: only slots below the record count are
// ever reported.
module sorted_key_record_table_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // part_key[31:0], amount[63:32], label_low[127:64], label_mid[191:128],
  // label_high[255:192]
  input  logic [skrt_pkg::REC_W-1:0] in_tdata,
  // action[1:0]
  input  logic [1:0]                 in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // out_key[31:0], out_quantity[63:32], out_label_low[127:64],
  // out_label_mid[191:128], out_label_high[255:192]
  output logic [skrt_pkg::REC_W-1:0] out_tdata,
  // status[1:0]
  output logic [1:0]                 out_tuser,
  output logic                       out_tlast
);

  localparam int DEPTH = skrt_pkg::TABLE_DEPTH;
  localparam int CNT_W = skrt_pkg::CNT_W;
  localparam int IDX_W = skrt_pkg::IDX_W;

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  dumping_r, dumping_nxt;
  logic [IDX_W-1:0]      dump_idx_r, dump_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  skrt_pkg::record_t     out_rec_r;
  skrt_pkg::status_t     out_status_r;
  logic                  out_last_r;

  skrt_pkg::record_t     req_rec;
  skrt_pkg::record_t     new_rec;
  skrt_pkg::action_t     action;
  skrt_pkg::cell_ctl_t   ctl;
  logic [DEPTH-1:0]      occupied;
  logic [DEPTH-1:0]      hit_vec;
  skrt_pkg::record_t     hit_rec;
  skrt_pkg::record_t     head_rec;
  logic                  any_hit, full, out_free, accept;
  logic                  emitting, dump_step, ins_ok;
  logic                  load;
  skrt_pkg::record_t     res_rec;
  skrt_pkg::status_t     res_status;
  logic                  res_last;

  // Decode the request
  assign req_rec = skrt_pkg::record_t'(in_tdata);
  assign action  = skrt_pkg::action_t'(in_tuser);

  always_comb begin
    new_rec = req_rec;
    {new_rec.label_high, new_rec.label_mid, new_rec.label_low} =
      skrt_pkg::clean_label({req_rec.label_high, req_rec.label_mid, req_rec.label_low});
  end

  // Slots below the record count are occupied
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occupied[i] = (CNT_W'(i) < count_r);
    end
  end

  skrt_chain u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .occupied  (occupied),
    .probe_key (req_rec.key),
    .amount    (req_rec.quantity),
    .new_rec   (new_rec),
    .head_rec  (head_rec),
    .hit_vec   (hit_vec),
    .hit_rec   (hit_rec)
  );

  assign any_hit   = |hit_vec;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !dumping_r && out_free;
  assign accept    = in_tvalid && in_tready;
  assign ins_ok    = accept && (action == skrt_pkg::ACT_INSERT) && !full && !any_hit;
  assign emitting  = (CNT_W'(dump_idx_r) < count_r);
  assign dump_step = dumping_r && (!emitting || out_free);

  // Request handling and dump sequencing
  always_comb begin
    ctl          = '0;
    load         = 1'b0;
    res_rec      = '0;
    res_status   = skrt_pkg::ST_OK;
    res_last     = 1'b1;
    count_nxt    = count_r;
    dumping_nxt  = dumping_r;
    dump_idx_nxt = dump_idx_r;

    if (accept) begin
      case (action)
        skrt_pkg::ACT_INSERT: begin
          load = 1'b1;
          if (full) begin
            res_status  = skrt_pkg::ST_FULL;
            res_rec.key = req_rec.key;
          end else if (any_hit) begin
            res_status  = skrt_pkg::ST_DUPLICATE;
            res_rec.key = req_rec.key;
          end else begin
            ctl.ins   = 1'b1;
            res_rec   = new_rec;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        skrt_pkg::ACT_SEARCH, skrt_pkg::ACT_UPDATE: begin
          load    = 1'b1;
          ctl.upd = (action == skrt_pkg::ACT_UPDATE) && any_hit;
          if (any_hit) begin
            res_rec = hit_rec;
          end else begin
            res_status  = skrt_pkg::ST_NOT_FOUND;
            res_rec.key = req_rec.key;
          end
        end
        skrt_pkg::ACT_DUMP: begin
          if (count_r == '0) begin
            load       = 1'b1;
            res_status = skrt_pkg::ST_NOT_FOUND;
          end else begin
            dumping_nxt  = 1'b1;
            dump_idx_nxt = '0;
          end
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end

    // Rotate the ring one place; emit the head while records remain
    if (dump_step) begin
      ctl.rot = 1'b1;
      if (emitting) begin
        load     = 1'b1;
        res_rec  = head_rec;
        res_last = (CNT_W'(dump_idx_r) + CNT_W'(1) == count_r);
      end
      dump_idx_nxt = dump_idx_r + IDX_W'(1);
      if (dump_idx_r == IDX_W'(DEPTH - 1)) begin
        dumping_nxt  = 1'b0;
        dump_idx_nxt = '0;
      end
    end
  end

  // Hold the output transaction until it is taken
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dumping_r   <= 1'b0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      dumping_r   <= dumping_nxt;
      dump_idx_r  <= dump_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_rec_r    <= res_rec;
      out_status_r <= res_status;
      out_last_r   <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_rec_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // Record count stays within the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("record count beyond table depth");

  // Keys are unique, so at most one occupied cell matches while the ring is in place
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    !dumping_r |-> $onehot0(hit_vec))
    else $error("more than one cell matches the key");

  // A successful insert grows the table by one
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ins_ok |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not advance record count");

  // The table size does not change during a dump
  a_dump_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (dumping_r && $past(dumping_r)) |-> $stable(count_r))
    else $error("record count changed during dump");
`endif

endmodule

### design/skrt_cell.sv
// One table slot: holds a record, compares it with the probe key, shifts or rotates.
module skrt_cell (
  input  logic               clk,
  input  skrt_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  logic [31:0]        probe_key,
  input  logic [31:0]        amount,
  input  skrt_pkg::record_t  new_rec,
  input  skrt_pkg::record_t  prev_rec,
  input  logic               prev_lt,
  input  skrt_pkg::record_t  next_rec,
  output skrt_pkg::record_t  rec,
  output logic               lt,
  output logic               hit,
  output skrt_pkg::record_t  rep
);

  skrt_pkg::record_t rec_r;
  skrt_pkg::record_t rec_nxt;
  logic [32:0]       sum_w;
  logic [31:0]       sat_qty;

  // Compare against the broadcast key
  assign lt  = occupied && ($signed(rec_r.key) < $signed(probe_key));
  assign hit = occupied && (rec_r.key == probe_key);

  // Saturating add of the change
  assign sum_w = {rec_r.quantity[31], rec_r.quantity} + {amount[31], amount};
  always_comb begin
    if (sum_w[32] != sum_w[31]) begin
      sat_qty = sum_w[32] ? skrt_pkg::QTY_MIN : skrt_pkg::QTY_MAX;
    end else begin
      sat_qty = sum_w[31:0];
    end
  end

  // Report this slot's record when it matches
  always_comb begin
    rep = '0;
    if (hit) begin
      rep = rec_r;
      if (ctl.upd) begin
        rep.quantity = sat_qty;
      end
    end
  end

  // Hold, take the new record, shift from the left, or rotate from the right
  always_comb begin
    rec_nxt = rec_r;
    if (ctl.ins && !lt) begin
      rec_nxt = prev_lt ? new_rec : prev_rec;
    end else if (ctl.upd && hit) begin
      rec_nxt.quantity = sat_qty;
    end else if (ctl.rot) begin
      rec_nxt = next_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec = rec_r;

endmodule

### design/skrt_chain.sv
// Row of table cells with neighbor links and a merge of the matching record.
module skrt_chain (
  input  logic                             clk,
  input  skrt_pkg::cell_ctl_t              ctl,
  input  logic [skrt_pkg::TABLE_DEPTH-1:0] occupied,
  input  logic [31:0]                      probe_key,
  input  logic [31:0]                      amount,
  input  skrt_pkg::record_t                new_rec,
  output skrt_pkg::record_t                head_rec,
  output logic [skrt_pkg::TABLE_DEPTH-1:0] hit_vec,
  output skrt_pkg::record_t                hit_rec
);

  skrt_pkg::record_t                cell_rec [skrt_pkg::TABLE_DEPTH];
  skrt_pkg::record_t                cell_rep [skrt_pkg::TABLE_DEPTH];
  logic [skrt_pkg::TABLE_DEPTH-1:0] lt_vec;

  for (genvar i = 0; i < skrt_pkg::TABLE_DEPTH; i++) begin : g_cell
    skrt_pkg::record_t prev_rec;
    logic              prev_lt;
    skrt_pkg::record_t next_rec;

    // First cell sees no left neighbor; last cell wraps to the first
    if (i == 0) begin : g_first
      assign prev_rec = new_rec;
      assign prev_lt  = 1'b1;
    end else begin : g_inner
      assign prev_rec = cell_rec[i-1];
      assign prev_lt  = lt_vec[i-1];
    end
    if (i == skrt_pkg::TABLE_DEPTH - 1) begin : g_last
      assign next_rec = cell_rec[0];
    end else begin : g_mid
      assign next_rec = cell_rec[i+1];
    end

    skrt_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (occupied[i]),
      .probe_key (probe_key),
      .amount    (amount),
      .new_rec   (new_rec),
      .prev_rec  (prev_rec),
      .prev_lt   (prev_lt),
      .next_rec  (next_rec),
      .rec       (cell_rec[i]),
      .lt        (lt_vec[i]),
      .hit       (hit_vec[i]),
      .rep       (cell_rep[i])
    );
  end

  // Merge the reports; at most one cell matches
  always_comb begin
    hit_rec = '0;
    for (int i = 0; i < skrt_pkg::TABLE_DEPTH; i++) begin
      hit_rec = hit_rec | cell_rep[i];
    end
  end

  assign head_rec = cell_rec[0];

endmodule

### tb/table_result_checker.sv
// Checker for the sorted key record table: predicts each request's results and compares them.
module table_result_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [skrt_pkg::REC_W-1:0] in_tdata,
  input  logic [1:0]                 in_tuser,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [skrt_pkg::REC_W-1:0] out_tdata,
  input  logic [1:0]                 out_tuser,
  input  logic                       out_tlast,
  output int                         errors,
  output int                         pending
);
  import skrt_pkg::*;

  typedef struct {
    status_t status;
    record_t rec;
    logic    last;
  } table_result_t;

  // Shadow copy of the table, sorted by signed key
  record_t       rows [TABLE_DEPTH];
  int            row_count = 0;
  table_result_t expected_results [$];
  int            fail_total = 0;

  // Print one line per failure and count it; keep the log short on a broken build
  task automatic report_mismatch(input string what);
    if (fail_total < 60) begin
      $display("[%0t] table check: %s", $time, what);
    end
    fail_total++;
  endtask

  function automatic void queue_result(input status_t st, input record_t rec, input logic last);
    table_result_t r;
    r.status = st;
    r.rec    = rec;
    r.last   = last;
    expected_results.push_back(r);
  endfunction

  // Zero every character after the end of the name or past the name limit
  function automatic logic [191:0] trim_name(input logic [191:0] raw);
    logic [191:0] res;
    logic         ended;
    logic [7:0]   ch;
    res   = '0;
    ended = 1'b0;
    for (int i = 0; i < 24; i++) begin
      ch = raw[i*8 +: 8];
      if (ch == 8'h00 || i >= LABEL_CHARS) begin
        ended = 1'b1;
      end
      if (!ended) begin
        res[i*8 +: 8] = ch;
      end
    end
    return res;
  endfunction

  // Apply one request to the shadow table and queue the results it causes
  function automatic void apply_request(input action_t act, input record_t req);
    int           pos;
    logic         hit;
    longint       sum;
    record_t      miss;
    logic [191:0] name;
    pos = 0;
    while (pos < row_count && $signed(rows[pos].key) < $signed(req.key)) begin
      pos++;
    end
    hit      = (pos < row_count) && (rows[pos].key == req.key);
    miss     = '0;
    miss.key = req.key;
    case (act)
      ACT_INSERT: begin
        if (row_count >= TABLE_DEPTH) begin
          queue_result(ST_FULL, miss, 1'b1);
        end else if (hit) begin
          queue_result(ST_DUPLICATE, miss, 1'b1);
        end else begin
          name = trim_name({req.label_high, req.label_mid, req.label_low});
          for (int i = row_count; i > pos; i--) begin
            rows[i] = rows[i-1];
          end
          rows[pos].key        = req.key;
          rows[pos].quantity   = req.quantity;
          rows[pos].label_low  = name[63:0];
          rows[pos].label_mid  = name[127:64];
          rows[pos].label_high = name[191:128];
          row_count++;
          queue_result(ST_OK, rows[pos], 1'b1);
        end
      end
      ACT_SEARCH, ACT_UPDATE: begin
        if (!hit) begin
          queue_result(ST_NOT_FOUND, miss, 1'b1);
        end else begin
          if (act == ACT_UPDATE) begin
            // Saturate the sum at the signed 32-bit limits
            sum = longint'($signed(rows[pos].quantity)) + longint'($signed(req.quantity));
            if (sum > longint'($signed(QTY_MAX))) begin
              rows[pos].quantity = QTY_MAX;
            end else if (sum < longint'($signed(QTY_MIN))) begin
              rows[pos].quantity = QTY_MIN;
            end else begin
              rows[pos].quantity = sum[31:0];
            end
          end
          queue_result(ST_OK, rows[pos], 1'b1);
        end
      end
      default: begin
        if (row_count == 0) begin
          queue_result(ST_NOT_FOUND, '0, 1'b1);
        end else begin
          for (int i = 0; i < row_count; i++) begin
            queue_result(ST_OK, rows[i], (i == row_count - 1));
          end
        end
      end
    endcase
  endfunction

  // Predict on every input transaction, compare on every output transaction
  always @(posedge clk) begin
    table_result_t want;
    record_t       got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        apply_request(action_t'(in_tuser), record_t'(in_tdata));
      end
      if (out_tvalid && out_tready) begin
        got = record_t'(out_tdata);
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with no request outstanding, key %h", got.key));
        end else begin
          want = expected_results.pop_front();
          if (out_tuser != want.status) begin
            report_mismatch($sformatf("status got %0d want %0d (key %h)",
                                      out_tuser, want.status, want.rec.key));
          end
          if (got.key != want.rec.key) begin
            report_mismatch($sformatf("key got %h want %h", got.key, want.rec.key));
          end
          if (got.quantity != want.rec.quantity) begin
            report_mismatch($sformatf("quantity got %h want %h (key %h)",
                                      got.quantity, want.rec.quantity, want.rec.key));
          end
          if (got.label_low != want.rec.label_low) begin
            report_mismatch($sformatf("label_low got %h want %h (key %h)",
                                      got.label_low, want.rec.label_low, want.rec.key));
          end
          if (got.label_mid != want.rec.label_mid) begin
            report_mismatch($sformatf("label_mid got %h want %h (key %h)",
                                      got.label_mid, want.rec.label_mid, want.rec.key));
          end
          if (got.label_high != want.rec.label_high) begin
            report_mismatch($sformatf("label_high got %h want %h (key %h)",
                                      got.label_high, want.rec.label_high, want.rec.key));
          end
          if (out_tlast != want.last) begin
            report_mismatch($sformatf("last got %b want %b (key %h)",
                                      out_tlast, want.last, want.rec.key));
          end
        end
      end
    end
    pending <= expected_results.size();
    errors  <= fail_total;
  end

endmodule

### tb/testbench.sv
// Top of the record table testbench: clock, reset, request stimulus, output stalls, verdict.
module testbench;
  import skrt_pkg::*;

  localparam int CYCLE_LIMIT  = 800_000;
  localparam int RANDOM_ITEMS = 250;
  localparam int LONG_HOLD    = 300;

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [REC_W-1:0] in_tdata   = '0;
  logic [1:0]       in_tuser   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [REC_W-1:0] out_tdata;
  logic [1:0]       out_tuser;
  logic             out_tlast;
  logic             long_hold_req = 1'b0;
  int               errors;
  int               pending;
  logic [31:0]      offered_keys [$];

  sorted_key_record_table_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  table_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("testbench: errors");
    $finish;
  end

  // Mostly short idle gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Favor keys already offered so hits, duplicates and updates are common
  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (offered_keys.size() > 0 && r < 55) begin
      return offered_keys[$urandom_range(0, offered_keys.size() - 1)];
    end
    if (r < 65) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    if (r < 75) return $urandom_range(0, 40) - 20;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return QTY_MAX;
    if (r < 20) return QTY_MIN;
    if (r < 30) return $urandom_range(0, 20) - 10;
    return $urandom;
  endfunction

  // Names of random length, sometimes with junk after the terminating zero
  function automatic logic [191:0] pick_label();
    logic [191:0] w;
    int           len;
    logic         junk;
    if ($urandom_range(0, 99) < 15) begin
      return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end
    len  = $urandom_range(0, 24);
    junk = 1'($urandom_range(0, 1));
    w    = '0;
    for (int i = 0; i < 24; i++) begin
      if (i < len) begin
        w[i*8 +: 8] = 8'($urandom_range(1, 255));
      end else if (junk) begin
        w[i*8 +: 8] = 8'($urandom_range(0, 255));
      end
    end
    return w;
  endfunction

  // Offer one request after a random gap and hold it until accepted
  task automatic offer_request(input action_t act, input logic [31:0] key,
                               input logic [31:0] amount, input logic [191:0] label);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (act == ACT_INSERT) begin
      offered_keys.push_back(key);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {label, amount, key};
    do @(posedge clk); while (!in_tready);
  endtask

  // Output stalls: random stretches, plus one long hold-off to back the block up
  initial begin
    int   span;
    logic held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_tready <= 1'b1;
      if ($urandom_range(0, 99) < 85) begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        repeat ($urandom_range(40, 120)) @(posedge clk);
      end
      span = $urandom_range(0, 99);
      if (span < 45) span = 0;
      else if (span < 90) span = $urandom_range(1, 4);
      else span = $urandom_range(10, 60);
      if (span > 0) begin
        out_tready <= 1'b0;
        repeat (span) @(posedge clk);
      end
    end
  end

  // Request stimulus and verdict
  initial begin
    int      r;
    action_t act;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table, misses, extreme keys and quantities, name trimming
    offer_request(ACT_DUMP, 32'h0, 32'h0, '0);
    offer_request(ACT_SEARCH, 32'h0, 32'h0, '0);
    offer_request(ACT_UPDATE, 32'h5, 32'h1, '0);
    offer_request(ACT_INSERT, 32'h8000_0000, QTY_MAX, {192{1'b1}});
    offer_request(ACT_INSERT, 32'h7fff_ffff, QTY_MIN,
                  {64'hdead_beef_cafe_f00d, 64'h0102_0304_0506_0708,
                   64'h5a59_5800_4443_4241});
    offer_request(ACT_INSERT, 32'h0, 32'h0, {64'h1111_1111_1111_1111,
                  64'h2222_2222_2222_2222, 64'h3333_3333_3333_3300});
    offer_request(ACT_INSERT, 32'hffff_ffff, 32'hffff_ffff,
                  {64'h7777_7777_7777_7777, 64'h0, 64'h6867_6665_6463_6261});
    offer_request(ACT_INSERT, 32'h0, 32'h1234_5678, {192{1'b1}});
    offer_request(ACT_UPDATE, 32'h7fff_ffff, 32'hffff_ffff, '0);
    offer_request(ACT_UPDATE, 32'h8000_0000, 32'h1, '0);
    offer_request(ACT_UPDATE, 32'hffff_ffff, QTY_MAX, '0);
    offer_request(ACT_UPDATE, 32'h0, 32'h0, {192{1'b1}});
    offer_request(ACT_SEARCH, 32'h7fff_ffff, 32'h0, '0);
    offer_request(ACT_SEARCH, 32'h1, 32'h0, '0);
    offer_request(ACT_DUMP, 32'h0, 32'h0, '0);

    // Random mix; the table fills up along the way and stays full
    long_hold_req <= 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 30) act = ACT_INSERT;
      else if (r < 55) act = ACT_SEARCH;
      else if (r < 85) act = ACT_UPDATE;
      else act = ACT_DUMP;
      offer_request(act, pick_key(), pick_amount(), pick_label());
    end
    in_tvalid <= 1'b0;

    // Drain, then keep waiting for stray results before the verdict
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### sim.f
design/skrt_pkg.sv
design/skrt_cell.sv
design/skrt_chain.sv
design/sorted_key_record_table_unit.sv
tb/table_result_checker.sv
tb/testbench.sv
